/* src/ufd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared payload types, decoder state and byte-class constants.
// ----------------------------------------------------------------------------
package ufd_pkg;

  // Widths fixed by the item formats.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 31;
  localparam int unsigned OwedW  = 3;

  // Byte patterns used when classifying a byte.
  localparam logic [ByteW-1:0] LeadBad     = 8'hFE;
  localparam logic [ByteW-1:0] Lead6       = 8'hFC;
  localparam logic [ByteW-1:0] Lead5       = 8'hF8;
  localparam logic [ByteW-1:0] Lead4       = 8'hF0;
  localparam logic [ByteW-1:0] Lead3       = 8'hE0;
  localparam logic [ByteW-1:0] Lead2       = 8'hC0;
  localparam logic [ByteW-1:0] ContPrefix  = 8'h80;
  localparam logic [CodeW-1:0] Replacement = 31'h3F;

  // One input item.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             error_flag;
    logic             message_end;
  } out_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [CodeW-1:0] code_accumulator;
    logic [OwedW-1:0] bytes_owed;
    logic             discarding;
  } ufd_state_t;

  // What one decode step hands back to the top level.
  typedef struct packed {
    ufd_state_t state_next;
    logic       emit;
    out_t       result;
  } ufd_step_t;

endpackage

/* src/ufd_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Combinational update of the decoder state for one byte, with the result
// (if any) that the byte produces.
// ----------------------------------------------------------------------------
module ufd_step (
  input  ufd_pkg::in_t       item,
  input  ufd_pkg::ufd_state_t state,
  input  logic               lenient_mode,
  output ufd_pkg::ufd_step_t step
);
  import ufd_pkg::*;

  logic [ByteW-1:0] b;
  logic             last;
  logic             bad_lead;
  logic [OwedW-1:0] lead_owed;
  logic [6:0]       lead_mask;
  logic             is_cont;
  logic [OwedW-1:0] owed_dec;

  assign b    = item.data_byte;
  assign last = item.last_byte;

  // Classify the byte as a lead byte.
  assign bad_lead = (b >= LeadBad) || ((b >= ContPrefix) && (b < Lead2));
  assign is_cont  = ((b & Lead2) == ContPrefix);
  assign owed_dec = state.bytes_owed - OwedW'(1);

  always_comb begin
    priority if (b >= Lead6) begin
      lead_owed = 3'd5;
      lead_mask = 7'h01;
    end else if (b >= Lead5) begin
      lead_owed = 3'd4;
      lead_mask = 7'h03;
    end else if (b >= Lead4) begin
      lead_owed = 3'd3;
      lead_mask = 7'h07;
    end else if (b >= Lead3) begin
      lead_owed = 3'd2;
      lead_mask = 7'h0F;
    end else begin
      lead_owed = 3'd1;
      lead_mask = 7'h1F;
    end
  end

  // Main decode: one of drop, fault, plain emit or accumulate.
  always_comb begin
    logic fault;
    fault = 1'b0;
    step.state_next = state;
    step.emit       = 1'b0;
    step.result.code_point  = '0;
    step.result.error_flag  = 1'b0;
    step.result.message_end = last;

    if (state.discarding) begin
      // Drop everything up to and including the end of the message.
      if (last) begin
        step.state_next.discarding = 1'b0;
      end
    end else if (state.bytes_owed == '0) begin
      if (bad_lead) begin
        fault = 1'b1;
      end else if (b < ContPrefix) begin
        step.emit = 1'b1;
        step.result.code_point = CodeW'(b);
      end else if (last) begin
        fault = 1'b1;
      end else begin
        step.state_next.code_accumulator = CodeW'(b[6:0] & lead_mask);
        step.state_next.bytes_owed       = lead_owed;
      end
    end else if (!is_cont) begin
      fault = 1'b1;
    end else if (owed_dec == '0) begin
      // Final continuation byte completes the character.
      step.emit = 1'b1;
      step.result.code_point = {state.code_accumulator[CodeW-7:0], b[5:0]};
      step.state_next.code_accumulator = '0;
      step.state_next.bytes_owed       = '0;
    end else if (last) begin
      fault = 1'b1;
    end else begin
      step.state_next.code_accumulator = {state.code_accumulator[CodeW-7:0], b[5:0]};
      step.state_next.bytes_owed       = owed_dec;
    end

    // Malformed input: replace with '?', or report and discard up to the message end.
    if (fault) begin
      step.emit = 1'b1;
      step.state_next.code_accumulator = '0;
      step.state_next.bytes_owed       = '0;
      if (lenient_mode) begin
        step.result.code_point = Replacement;
      end else begin
        step.result.error_flag     = 1'b1;
        step.state_next.discarding = ~last;
      end
    end
  end

endmodule

/* src/utf8_stream_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Decodes a byte stream of legacy UTF-8 (up to six bytes, 31-bit code points)
// into code points, with '?' replacement or error-and-discard handling.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Direction  Content
//  item      item_valid/item_stall/item      in         data_byte, last_byte
//  result    result_valid/result_stall/...   out        code_point, flags
//  config    cfg_write/cfg_data              in         lenient_mode
//
// One byte is taken per cycle while item_stall is low. A byte's transfer loads
// the input register; when the byte moves on, its result is loaded into the
// result register, from which it is offered and transferred.
// The decode of a byte is one pass of logic between those two registers.
// Reset clears the decoder state, both valid flags and lenient_mode.
// A stalled result holds; the input register keeps moving while the step
// produces no result or the result register can take one.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  ufd_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output ufd_pkg::out_t result,
  input  logic          cfg_write,
  input  logic          cfg_data
);
  import ufd_pkg::*;

  logic       lenient_mode;
  logic       hold_valid;
  in_t        hold_item;
  ufd_state_t state;
  ufd_step_t  step;
  logic       accept;
  logic       fire;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lenient_mode <= 1'b0;
    end else if (cfg_write) begin
      lenient_mode <= cfg_data;
    end
  end

  // Decode of the byte in the input register.
  ufd_step u_step (
    .item         (hold_item),
    .state        (state),
    .lenient_mode (lenient_mode),
    .step         (step)
  );

  // The held byte moves on unless its result has nowhere to go.
  assign fire       = hold_valid && (!step.emit || !result_valid || !result_stall);
  assign item_stall = hold_valid && !fire;
  assign accept     = item_valid && !item_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= item;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= step.state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && step.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      result <= step.result;
    end
  end

  // Checks on the decoder's own logic.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_flag |-> result.code_point == '0)
    else $error("error result carries a non-zero code point");

  a_discard_clean: assert property (@(posedge clk) disable iff (rst)
    state.discarding |-> state.bytes_owed == '0 && state.code_accumulator == '0)
    else $error("discarding with a sequence still open");

  a_owed_range: assert property (@(posedge clk) disable iff (rst)
    state.bytes_owed <= OwedW'(5))
    else $error("more than five continuation bytes owed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !hold_valid)
    else $error("pipeline not empty after reset");

endmodule

/* dv/utf8_stream_decoder_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit testbench
// Drives bytes through the decoder with random gaps and result stalls, mirrors
// the decode in a predictor and checks every result transfer field by field.
// Covers strict and lenient handling, six-byte sequences and mode changes.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit_test;
  import ufd_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomBytes = 2000;
  localparam int unsigned ReportCap   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t  item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  // Predictor copy of the decoder state and the mode register.
  logic [CodeW-1:0] code_acc;
  logic [OwedW-1:0] owed;
  logic             dropping;
  logic             lenient;
  out_t             expected_chars[$];

  int unsigned mismatch_count = 0;
  int unsigned decoded_bytes = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  utf8_stream_decoder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // A malformed input clears the sequence and gives either '?' or an error.
  function automatic out_t decode_fault(logic last);
    out_t r;
    r = '0;
    code_acc = '0;
    owed = '0;
    if (lenient) begin
      r.code_point = Replacement;
    end else begin
      r.error_flag = 1'b1;
      dropping = !last;
    end
    r.message_end = last;
    return r;
  endfunction

  // Advances the predictor by one accepted byte and queues any character due.
  function automatic void decode_byte(in_t it);
    logic [ByteW-1:0] b;
    logic [OwedW-1:0] n;
    out_t             r;
    bit               produces;
    b = it.data_byte;
    r = '0;
    produces = 1'b0;
    if (dropping) begin
      if (it.last_byte) dropping = 1'b0;
      return;
    end
    decoded_bytes++;
    if (owed == '0) begin
      if (b >= LeadBad || (b >= ContPrefix && b < Lead2)) begin
        r = decode_fault(it.last_byte);
        produces = 1'b1;
      end else if (b < ContPrefix) begin
        r.code_point = CodeW'(b);
        r.message_end = it.last_byte;
        produces = 1'b1;
      end else begin
        if (b >= Lead6) n = 3'd5;
        else if (b >= Lead5) n = 3'd4;
        else if (b >= Lead4) n = 3'd3;
        else if (b >= Lead3) n = 3'd2;
        else n = 3'd1;
        if (it.last_byte) begin
          r = decode_fault(1'b1);
          produces = 1'b1;
        end else begin
          code_acc = CodeW'(b & (8'hFF >> (n + 1)));
          owed = n;
        end
      end
    end else if (b[7:6] != ContPrefix[7:6]) begin
      r = decode_fault(it.last_byte);
      produces = 1'b1;
    end else begin
      code_acc = {code_acc[CodeW-7:0], b[5:0]};
      owed = owed - OwedW'(1);
      if (owed == '0) begin
        r.code_point = code_acc;
        r.message_end = it.last_byte;
        code_acc = '0;
        produces = 1'b1;
      end else if (it.last_byte) begin
        r = decode_fault(1'b1);
        produces = 1'b1;
      end
    end
    if (produces) expected_chars = {expected_chars, r};
  endfunction

  task automatic report_mismatch(string what, logic [CodeW-1:0] want, logic [CodeW-1:0] got);
    if (mismatch_count < ReportCap)
      $display("%0t ns: mismatch in %s, expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Compares one result transfer with the oldest expected character.
  task automatic check_char(out_t got);
    out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("unexpected result", '0, got.code_point);
      return;
    end
    want = expected_chars.pop_front();
    if (got.code_point != want.code_point)
      report_mismatch("code_point", want.code_point, got.code_point);
    if (got.error_flag != want.error_flag)
      report_mismatch("error_flag", CodeW'(want.error_flag), CodeW'(got.error_flag));
    if (got.message_end != want.message_end)
      report_mismatch("message_end", CodeW'(want.message_end), CodeW'(got.message_end));
  endtask

  // Observes every transfer and register write at the clock edge; also
  // watches for the design going quiet for too long.
  always @(posedge clk) begin
    if (rst) begin
      code_acc = '0;
      owed = '0;
      dropping = 1'b0;
      lenient = 1'b0;
      expected_chars.delete();
      idle_cycles = 0;
    end else begin
      if (item_valid && !item_stall) decode_byte(item);
      if (result_valid && !result_stall) check_char(result);
      if (cfg_write) lenient = cfg_data;
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("utf8_stream_decoder_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Result side back-pressure in random bursts.
  initial begin : result_stall_driver
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Offers one byte after a random gap and waits for its transfer.
  task automatic send_byte(logic [ByteW-1:0] b, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Stops offering bytes and lets every outstanding character arrive.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_mode(logic mode);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Strict handling straight after reset: plain characters, bad leads,
  // truncated ends, broken sequences and the discard that follows an error.
  task automatic test_strict_errors();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h20, 1'b1);
  endtask

  // Lenient replacement, then the largest six-byte code point.
  task automatic test_lenient_repair();
    int k;
    set_mode(1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h28, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hFD, 1'b0);
    for (k = 0; k < 5; k++) send_byte(8'hBF, k == 4);
  endtask

  // The mode at the moment of the fault decides; a discard outlives a mode change.
  task automatic test_mode_switch();
    set_mode(1'b0);
    send_byte(8'hE0, 1'b0);
    set_mode(1'b1);
    send_byte(8'h41, 1'b0);
    set_mode(1'b0);
    send_byte(8'h80, 1'b0);
    set_mode(1'b1);
    send_byte(8'h41, 1'b1);
  endtask

  // One character of random length and content, sometimes corrupted or cut short.
  task automatic send_char(bit closes);
    logic [ByteW-1:0] seq [6];
    int unsigned      len;
    int unsigned      roll;
    int unsigned      k;
    roll = $urandom_range(0, 99);
    if (roll < 40) len = 1;
    else if (roll < 60) len = 2;
    else if (roll < 75) len = 3;
    else if (roll < 85) len = 4;
    else if (roll < 93) len = 5;
    else len = 6;
    case (len)
      1: seq[0] = ByteW'($urandom_range(0, 127));
      2: seq[0] = Lead2 | ByteW'($urandom_range(0, 31));
      3: seq[0] = Lead3 | ByteW'($urandom_range(0, 15));
      4: seq[0] = Lead4 | ByteW'($urandom_range(0, 7));
      5: seq[0] = Lead5 | ByteW'($urandom_range(0, 3));
      default: seq[0] = Lead6 | ByteW'($urandom_range(0, 1));
    endcase
    for (k = 1; k < len; k++) seq[k] = ContPrefix | ByteW'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < 5) seq[$urandom_range(0, len - 1)] = ByteW'($urandom_range(0, 255));
    else if (roll < 10 && len > 1) len = $urandom_range(1, len - 1);
    for (k = 0; k < len; k++) send_byte(seq[k], closes && k == len - 1);
  endtask

  // Random messages over several mode settings, one phase without idling.
  task automatic test_random_stream();
    int unsigned phase;
    int unsigned chars;
    int unsigned base;
    int unsigned i;
    base = decoded_bytes;
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 2) set_mode(phase[0]);
      else set_mode(1'($urandom_range(0, 1)));
      no_idle = (phase == 5);
      while (decoded_bytes - base < (phase + 1) * RandomBytes / 8) begin
        chars = $urandom_range(1, 10);
        for (i = 0; i < chars; i++) send_char(i == chars - 1);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_strict_errors();
    test_lenient_repair();
    test_mode_switch();
    test_random_stream();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("utf8_stream_decoder_unit_test OK");
    end else begin
      $display("utf8_stream_decoder_unit_test NOT OK");
    end
    $finish;
  end

endmodule
